### rtl/asc_pkg.sv
`default_nettype none
package asc_pkg;
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int SUM_W = 19;
  localparam int OUT_W = 11;
  localparam int TICK_W = 31;
  localparam int NUM_AXES = 3;
  localparam int DIV_W = 20;

  localparam logic [2:0] REG_SCALE_X = 3'd0;
  localparam logic [2:0] REG_SCALE_Y = 3'd1;
  localparam logic [2:0] REG_SCALE_Z = 3'd2;
  localparam logic [2:0] REG_BIAS_X  = 3'd3;
  localparam logic [2:0] REG_BIAS_Y  = 3'd4;
  localparam logic [2:0] REG_BIAS_Z  = 3'd5;
  localparam logic [2:0] REG_AVG     = 3'd6;
  localparam logic [2:0] REG_OPTIONS = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_FINAL,
    ST_OUT
  } state_t;

  // lane divider handshake
  typedef struct packed {
    logic start;
    logic busy;
  } lane_ctl_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [DIV_W:0] v);
    logic signed [OUT_W-1:0] r;
    begin
      if (v > 1023) r = 11'sd1023;
      else if (v < -1024) r = -11'sd1024;
      else r = v[OUT_W-1:0];
      return r;
    end
  endfunction
endpackage
`default_nettype wire

### rtl/asc_if.sv
`default_nettype none
interface asc_in_if #(parameter int SB = 10);
  logic valid;
  logic ready;
  logic signed [SB-1:0] raw_x;
  logic signed [SB-1:0] raw_y;
  logic signed [SB-1:0] raw_z;
  logic [2:0] orient_code;
  logic is_flat;
  modport source(output valid, raw_x, raw_y, raw_z, orient_code, is_flat, input ready);
  modport sink(input valid, raw_x, raw_y, raw_z, orient_code, is_flat, output ready);
endinterface

interface asc_out_if;
  logic valid;
  logic ready;
  logic signed [10:0] out_x;
  logic signed [10:0] out_y;
  logic signed [10:0] out_z;
  logic [2:0] orient_out;
  logic orient_valid;
  logic [30:0] tick_value;
  logic tick_valid;
  modport source(output valid, out_x, out_y, out_z, orient_out, orient_valid,
                 tick_value, tick_valid, input ready);
  modport sink(input valid, out_x, out_y, out_z, orient_out, orient_valid,
               tick_value, tick_valid, output ready);
endinterface
`default_nettype wire

### rtl/accel_sample_conditioner_unit.sv
`default_nettype none
// Accelerometer sample conditioner.
// Input channel: one raw x/y/z sample with orientation code and flat flag.
// Result channel: saturated x/y/z, remapped orientation and report tick.
// Config port: cfg_we/cfg_idx/cfg_wdata; the user must see that it is
// written only while idle, which the block itself does not enforce. Three
// axis lanes each scale and accumulate their axis; a serial divider in
// every lane gives one quotient bit per cycle. A sample is scaled in the
// scale state, with a divide only for a general scale divisor, and emitted
// from the final state; a sample that closes an averaging group instead
// gets a final divide in the out state and is emitted from there; a
// sample that closes no group gives no result.
// One sample at a time: in_ready is high only when no sample is in work.
// While the receiver stalls the result holds in the output register; the
// next sample may still be taken and worked; one that has a result then
// waits for the output register and no further sample is taken.
// Reset (synchronous, active low) restores register defaults and clears
// sums, sample count and the report tick counter.
module accel_sample_conditioner_unit #(
  parameter int SAMPLE_BITS = asc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  asc_in_if.sink          in_ch,
  asc_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_idx,
  input  wire logic [9:0] cfg_wdata
);
  import asc_pkg::*;

  logic signed [4:0] scale_r [NUM_AXES];
  logic signed [9:0] bias_r [NUM_AXES];
  logic [7:0]  avg_r;
  logic [2:0]  opt_r;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  state_t      st_r, st_nxt;
  logic [2:0]  orient_r, orient_nxt;
  logic        ovld_r;
  logic signed [OUT_W-1:0] ox_r, oy_r, oz_r;
  logic [2:0]  oori_r;
  logic        oov_r, otv_r;
  logic [TICK_W-1:0] otick_r;
  logic        wait_r, wait_nxt;

  lane_ctl_t   ctl;
  logic        load, acc, clr, fin, emit, ovld_nxt, fin_r, fin_nxt;
  logic        out_free;
  logic [NUM_AXES-1:0] busy;
  logic signed [OUT_W-1:0] res [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] lane_raw [NUM_AXES];
  logic        avg_on;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        scale_r[i] <= 5'sd1; bias_r[i] <= '0;
      end
      avg_r <= 8'd1; opt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SCALE_X: scale_r[0] <= cfg_wdata[4:0];
        REG_SCALE_Y: scale_r[1] <= cfg_wdata[4:0];
        REG_SCALE_Z: scale_r[2] <= cfg_wdata[4:0];
        REG_BIAS_X:  bias_r[0] <= cfg_wdata;
        REG_BIAS_Y:  bias_r[1] <= cfg_wdata;
        REG_BIAS_Z:  bias_r[2] <= cfg_wdata;
        REG_AVG:     avg_r <= cfg_wdata[7:0];
        REG_OPTIONS: opt_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  assign avg_on = avg_r > 8'd1;
  assign lane_raw[0] = opt_r[1] ? in_ch.raw_y : in_ch.raw_x;
  assign lane_raw[1] = opt_r[1] ? in_ch.raw_x : in_ch.raw_y;
  assign lane_raw[2] = in_ch.raw_z;

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    asc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
      .clk(clk), .rst_n(rst_n), .raw(lane_raw[g]), .scale(scale_r[g]),
      .bias(bias_r[g]), .avg(avg_r), .ctl(ctl), .load(load), .acc(acc),
      .clr(clr), .fin(fin), .busy(busy[g]), .res(res[g])
    );
  end

  assign in_ch.ready = (st_r == ST_IDLE);
  assign load = in_ch.valid && in_ch.ready;
  // output register can take a result this cycle
  assign out_free = !ovld_r || out_ch.ready;

  // orientation remap
  always_comb begin
    logic [2:0] o;
    o = in_ch.is_flat ? 3'd1 : in_ch.orient_code;
    if (opt_r[1]) o = 3'd7 - o;
    else begin
      if (scale_r[0][4] && !o[1]) o = o ^ 3'd1;
      if (scale_r[1][4] && o[1]) o = o ^ 3'd1;
    end
    orient_nxt = opt_r[0] ? o : 3'd0;
  end

  // sequencer: scale, optional average divide, emit
  always_comb begin
    st_nxt = st_r; ctl.start = 1'b0; ctl.busy = 1'b0;
    acc = 1'b0; clr = 1'b0; emit = 1'b0; cnt_nxt = cnt_r;
    wait_nxt = wait_r; fin_nxt = fin_r;
    case (st_r)
      ST_IDLE: if (load) st_nxt = ST_SCALE;
      ST_SCALE: begin
        ctl.busy = wait_r;
        if (!wait_r) begin
          ctl.start = 1'b1; wait_nxt = 1'b1;
        end else if (busy == '0) begin
          wait_nxt = 1'b0;
          st_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (!avg_on) begin
          if (out_free) begin
            emit = 1'b1; st_nxt = ST_IDLE;
          end
        end else if (!fin_r) begin
          acc = 1'b1;
          cnt_nxt = cnt_r + 8'd1;
          if (cnt_nxt >= avg_r) begin
            fin_nxt = 1'b1; st_nxt = ST_OUT;
          end else st_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!wait_r) begin
          ctl.start = 1'b1; wait_nxt = 1'b1;
        end else if (busy == '0 && out_free) begin
          wait_nxt = 1'b0; emit = 1'b1; clr = 1'b1; cnt_nxt = '0;
          fin_nxt = 1'b0; st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end
  assign fin = fin_r;

  assign ovld_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : ovld_r);
  assign tick_nxt = (emit && opt_r[2]) ? tick_r + 31'd1 : tick_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; cnt_r <= '0; tick_r <= '0; ovld_r <= 1'b0;
      wait_r <= 1'b0; fin_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; tick_r <= tick_nxt; ovld_r <= ovld_nxt;
      wait_r <= wait_nxt; fin_r <= fin_nxt;
    end
    if (load) orient_r <= orient_nxt;
    // capture the result register
    if (emit) begin
      ox_r <= res[0]; oy_r <= res[1]; oz_r <= res[2];
      oori_r <= orient_r; oov_r <= opt_r[0]; otv_r <= opt_r[2];
      otick_r <= opt_r[2] ? tick_r : '0;
    end
  end

  assign out_ch.valid = ovld_r;
  assign out_ch.out_x = ox_r;
  assign out_ch.out_y = oy_r;
  assign out_ch.out_z = oz_r;
  assign out_ch.orient_out = oori_r;
  assign out_ch.orient_valid = oov_r;
  assign out_ch.tick_value = otick_r;
  assign out_ch.tick_valid = otv_r;
endmodule
`default_nettype wire

### rtl/asc_lane_div.sv
`default_nettype none
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
module asc_lane_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic signed [asc_pkg::DIV_W-1:0] dividend,
  input  wire logic [8:0]                    divisor,
  input  wire logic                          div_neg,
  output      logic                          busy,
  output      logic signed [asc_pkg::DIV_W:0] quotient
);
  import asc_pkg::*;

  logic [DIV_W-1:0] q_r, q_nxt;
  logic [9:0]       rem_r, rem_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             neg_r, neg_nxt;
  logic [8:0]       d_r, d_nxt;
  logic [10:0]      trial;
  logic [DIV_W-1:0] mag;

  assign mag = dividend[DIV_W-1] ? DIV_W'(-dividend) : dividend;
  assign trial = {rem_r, q_r[DIV_W-1]} - {2'b0, d_r};

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    neg_nxt = neg_r; d_nxt = d_r;
    if (start) begin
      q_nxt = mag; rem_nxt = '0; cnt_nxt = 5'(DIV_W); busy_nxt = 1'b1;
      neg_nxt = dividend[DIV_W-1] ^ div_neg; d_nxt = divisor;
    end else if (busy_r) begin
      // shift one bit, subtract when it fits
      if (!trial[10]) begin
        rem_nxt = trial[9:0];
        q_nxt = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[8:0], q_r[DIV_W-1]};
        q_nxt = {q_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; neg_r <= neg_nxt; d_r <= d_nxt;
  end

  assign busy = busy_r | start;
  assign quotient = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
endmodule
`default_nettype wire

### rtl/asc_lane.sv
`default_nettype none
// One axis: scale, accumulate, bias and divide for the final result.
module asc_lane #(
  parameter int SAMPLE_BITS = asc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic signed [SAMPLE_BITS-1:0]  raw,
  input  wire logic signed [4:0]              scale,
  input  wire logic signed [9:0]              bias,
  input  wire logic [7:0]                     avg,
  input  wire asc_pkg::lane_ctl_t             ctl,
  input  wire logic                           load,
  input  wire logic                           acc,
  input  wire logic                           clr,
  input  wire logic                           fin,
  output      logic                           busy,
  output      logic signed [asc_pkg::OUT_W-1:0] res
);
  import asc_pkg::*;

  logic signed [SAMPLE_BITS-1:0] v_r;
  logic signed [SAMPLE_BITS+1:0] sc_r;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic signed [DIV_W-1:0]       dvd;
  logic [8:0]                    dvs;
  logic                          dneg;
  logic signed [DIV_W:0]         q;
  logic                          div_busy;
  logic signed [SAMPLE_BITS+1:0] ve, neg_v;
  logic [4:0]                    kmag;
  logic                          scale_div;

  assign ve = (SAMPLE_BITS+2)'(v_r);
  assign neg_v = -ve;
  assign kmag = scale[4] ? 5'(-scale) : scale;
  assign scale_div = !(scale == 5'sd0 || scale == 5'sd1 || scale == -5'sd1 ||
                       scale == 5'sd4 || scale == -5'sd4);

  // hold sample, then keep the scaled value
  always_ff @(posedge clk) begin
    if (load) v_r <= raw;
    if (ctl.start && !fin) begin
      case (scale)
        5'sd0, 5'sd1: sc_r <= ve;
        -5'sd1:       sc_r <= neg_v;
        5'sd4:        sc_r <= ve >>> 2;
        -5'sd4:       sc_r <= neg_v >>> 2;
        default:      sc_r <= ve;
      endcase
    end else if (!ctl.start && !div_busy && ctl.busy && scale_div)
      sc_r <= (SAMPLE_BITS+2)'(q);
  end

  // divider feeds: scale step or final average
  always_comb begin
    if (fin) begin
      dvd = DIV_W'(sum_r) - DIV_W'(bias);
      dvs = {1'b0, avg};
      dneg = 1'b0;
    end else begin
      dvd = DIV_W'(v_r);
      dvs = {4'b0, kmag};
      dneg = scale[4];
    end
  end

  asc_lane_div u_div (
    .clk(clk), .rst_n(rst_n),
    .start(ctl.start && (fin || scale_div)),
    .dividend(dvd), .divisor(dvs), .div_neg(dneg),
    .busy(div_busy), .quotient(q)
  );

  always_comb begin
    sum_nxt = sum_r;
    if (clr) sum_nxt = '0;
    else if (acc) sum_nxt = sum_r + SUM_W'(sc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sum_r <= '0;
    else sum_r <= sum_nxt;
  end

  assign busy = div_busy;
  assign res = fin ? sat_out(q) : sat_out((DIV_W+1)'(sc_r) - (DIV_W+1)'(bias));
endmodule
`default_nettype wire

### dv/accel_sample_conditioner_unit_test.sv
`timescale 1ns / 100ps
`default_nettype none
module accel_sample_conditioner_unit_test;
  import asc_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int SETTLE_CYCLES = 80;

  typedef struct packed {
    logic signed [SB-1:0] raw_x;
    logic signed [SB-1:0] raw_y;
    logic signed [SB-1:0] raw_z;
    logic [2:0]           orient_code;
    logic                 is_flat;
  } sample_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    logic signed [OUT_W-1:0] out_z;
    logic [2:0]              orient_out;
    logic                    orient_valid;
    logic [TICK_W-1:0]       tick_value;
    logic                    tick_valid;
  } cond_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [9:0] cfg_wdata;

  asc_in_if #(.SB(SB)) in_ch();
  asc_out_if out_ch();

  accel_sample_conditioner_unit #(.SAMPLE_BITS(SB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // shadow registers and accumulator state
  logic signed [4:0] k_x, k_y, k_z;
  logic signed [9:0] off_x, off_y, off_z;
  logic [7:0] avg_n;
  logic [2:0] opts;
  logic signed [SUM_W-1:0] acc_x, acc_y, acc_z;
  logic [7:0] acc_cnt;
  logic [TICK_W-1:0] ticks;

  sample_t pending[$];
  cond_result_t expected_results[$];
  int send_idle_pct, recv_idle_pct;
  int mismatches, results_seen, samples_sent;
  int hold_req, hold_served, hold_left;

  function automatic int scale_axis(int v, int k);
    case (k)
      0, 1: return v;
      -1: return -v;
      4: return v >>> 2;
      -4: return (-v) >>> 2;
      default: return v / k;
    endcase
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_out(int v);
    if (v > 1023) return 11'sd1023;
    if (v < -1024) return -11'sd1024;
    return v[OUT_W-1:0];
  endfunction

  // Work out the result for one accepted sample; returns 0 if none is due.
  function automatic bit predict_conditioned(sample_t s, output cond_result_t r);
    int x, y, z, t, rx, ry, rz;
    logic [2:0] o;
    x = s.raw_x; y = s.raw_y; z = s.raw_z;
    o = s.orient_code;
    if (opts[1]) begin
      t = x; x = y; y = t;
    end
    x = scale_axis(x, k_x);
    y = scale_axis(y, k_y);
    z = scale_axis(z, k_z);
    if (opts[0]) begin
      if (s.is_flat) o = 3'd1;
      if (opts[1]) o = 3'd7 - o;
      else begin
        if (k_x < 0 && o[1] == 1'b0) o[0] = ~o[0];
        if (k_y < 0 && o[1] == 1'b1) o[0] = ~o[0];
      end
    end else o = 3'd0;
    if (avg_n > 1) begin
      acc_x = SUM_W'(acc_x + x);
      acc_y = SUM_W'(acc_y + y);
      acc_z = SUM_W'(acc_z + z);
      acc_cnt = acc_cnt + 8'd1;
      if (acc_cnt < avg_n) return 0;
      rx = (int'(acc_x) - off_x) / int'(avg_n);
      ry = (int'(acc_y) - off_y) / int'(avg_n);
      rz = (int'(acc_z) - off_z) / int'(avg_n);
      acc_x = '0; acc_y = '0; acc_z = '0; acc_cnt = '0;
    end else begin
      rx = x - off_x; ry = y - off_y; rz = z - off_z;
    end
    r.out_x = clamp_out(rx);
    r.out_y = clamp_out(ry);
    r.out_z = clamp_out(rz);
    r.orient_out = o;
    r.orient_valid = opts[0];
    if (opts[2]) begin
      r.tick_value = ticks;
      ticks = ticks + 31'd1;
      r.tick_valid = 1'b1;
    end else begin
      r.tick_value = '0;
      r.tick_valid = 1'b0;
    end
    return 1;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Driver: offer pending samples, predict on each transfer.
  always @(posedge clk) begin
    cond_result_t r;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        samples_sent++;
        if (predict_conditioned({in_ch.raw_x, in_ch.raw_y, in_ch.raw_z,
                                 in_ch.orient_code, in_ch.is_flat}, r))
          expected_results.push_back(r);
      end
      if ((!in_ch.valid || in_ch.ready) ) begin
        if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_t s;
          s = pending.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.raw_x <= s.raw_x;
          in_ch.raw_y <= s.raw_y;
          in_ch.raw_z <= s.raw_z;
          in_ch.orient_code <= s.orient_code;
          in_ch.is_flat <= s.is_flat;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    else if (hold_req != hold_served) begin
      hold_left <= 400;
      hold_served <= hold_served + 1;
    end
  end

  // Monitor: check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    cond_result_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.orient_out,
               out_ch.orient_valid, out_ch.tick_value, out_ch.tick_valid};
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(logic [2:0] idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val[9:0];
    case (idx)
      REG_SCALE_X: k_x = val[4:0];
      REG_SCALE_Y: k_y = val[4:0];
      REG_SCALE_Z: k_z = val[4:0];
      REG_BIAS_X:  off_x = val[9:0];
      REG_BIAS_Y:  off_y = val[9:0];
      REG_BIAS_Z:  off_z = val[9:0];
      REG_AVG:     avg_n = val[7:0];
      REG_OPTIONS: opts = val[2:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SB-1:0] pick_raw();
    case ($urandom_range(7))
      0: return 10'sh200;
      1: return 10'sh1FF;
      2: return '0;
      default: return SB'($urandom);
    endcase
  endfunction

  task automatic run_phase(int sx, int sy, int sz, int bx, int by, int bz,
                           int avg, int opt, int n);
    sample_t s;
    wait_drained();
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    write_reg(REG_SCALE_Z, sz);
    write_reg(REG_BIAS_X, bx);
    write_reg(REG_BIAS_Y, by);
    write_reg(REG_BIAS_Z, bz);
    write_reg(REG_AVG, avg);
    write_reg(REG_OPTIONS, opt);
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (n) begin
      s.raw_x = pick_raw();
      s.raw_y = pick_raw();
      s.raw_z = pick_raw();
      s.orient_code = 3'($urandom_range(7));
      s.is_flat = 1'($urandom_range(1));
      pending.push_back(s);
    end
  endtask

  function automatic int rnd_scale();
    return $urandom_range(16) - 8;
  endfunction

  function automatic int rnd_bias();
    return $urandom_range(1023) - 512;
  endfunction

  initial begin
    sample_t s;
    int extremes[4];
    extremes = '{-512, 511, 0, -1};
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0;
    in_ch.valid = 1'b0; in_ch.raw_x = '0; in_ch.raw_y = '0; in_ch.raw_z = '0;
    in_ch.orient_code = '0; in_ch.is_flat = 1'b0;
    out_ch.ready = 1'b0;
    send_idle_pct = 15; recv_idle_pct = 53;
    mismatches = 0; results_seen = 0; samples_sent = 0;
    hold_req = 0; hold_served = 0; hold_left = 0;
    k_x = 1; k_y = 1; k_z = 1; off_x = 0; off_y = 0; off_z = 0;
    avg_n = 1; opts = '0;
    acc_x = '0; acc_y = '0; acc_z = '0; acc_cnt = '0; ticks = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes under reset configuration
    for (int i = 0; i < 16; i++) begin
      s.raw_x = SB'(extremes[i % 4]);
      s.raw_y = SB'(extremes[(i + 1) % 4]);
      s.raw_z = SB'(extremes[(i + 2) % 4]);
      s.orient_code = 3'(i % 8);
      s.is_flat = i[3];
      pending.push_back(s);
    end

    // negative x/y scales with orientation, shift scales
    run_phase(4, -4, -1, 511, -512, 0, 1, 1, 130);
    run_phase(-8, 8, 0, -512, 511, 7, 0, 3, 130);
    run_phase(3, -5, 7, rnd_bias(), rnd_bias(), rnd_bias(), 3, 5, 131);
    send_idle_pct = 53; recv_idle_pct = 15;
    // group of five left open, then lowered to two mid-group
    run_phase(2, -3, -7, 0, 0, 0, 5, 7, 132);
    hold_req = 1;
    run_phase(1, 1, 1, rnd_bias(), rnd_bias(), rnd_bias(), 2, 4, 131);
    // averaging off keeps the partial sums, then resumes
    run_phase(-2, 6, -6, 0, 0, 0, 3, 1, 130);
    run_phase(-2, 6, -6, rnd_bias(), rnd_bias(), rnd_bias(), 0, 1, 130);
    send_idle_pct = 0; recv_idle_pct = 0;
    run_phase(-1, -1, -1, rnd_bias(), rnd_bias(), rnd_bias(), 3, 7, 130);
    run_phase(rnd_scale(), rnd_scale(), rnd_scale(), -512, -512, -512, 255, 4, 520);
    repeat (2)
      run_phase(rnd_scale(), rnd_scale(), rnd_scale(), rnd_bias(), rnd_bias(),
                rnd_bias(), $urandom_range(4), $urandom_range(7), 130);
    wait_drained();

    $display("covered %0d samples, %0d results, scales -8..8, averaging 0..255",
             samples_sent, results_seen);
    if (mismatches == 0) begin
      $display("accel_sample_conditioner_unit_test: done, clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("accel_sample_conditioner_unit_test: done, errors");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("timeout");
    $display("accel_sample_conditioner_unit_test: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
rtl/asc_pkg.sv
rtl/asc_if.sv
rtl/asc_lane_div.sv
rtl/asc_lane.sv
rtl/accel_sample_conditioner_unit.sv
dv/accel_sample_conditioner_unit_test.sv
